// ===== hdl/sbe_pkg.sv =====
// Shared types and constants for the stack bytecode executor.
`default_nettype none
package sbe_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int ENTRY_W     = 65;
  localparam int DEPTH_W     = 9;

  localparam logic [63:0] CANON_NAN = 64'h7FF8_0000_0000_0000;

  typedef enum logic [2:0] {
    OP_CONST      = 3'd0,
    OP_CONST_LONG = 3'd1,
    OP_NEG        = 3'd2,
    OP_ADD        = 3'd3,
    OP_SUB        = 3'd4,
    OP_MUL        = 3'd5,
    OP_DIV        = 3'd6,
    OP_RET        = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_OK    = 3'd0,
    ST_RET   = 3'd1,
    ST_TYPE  = 3'd2,
    ST_OVER  = 3'd3,
    ST_UNDER = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FP_ADD,
    FP_SUB,
    FP_MUL,
    FP_DIV
  } fp_op_e;

  typedef enum logic [2:0] {
    T_IDLE,
    T_EXEC,
    T_READ,
    T_ARITH,
    T_FINISH
  } top_state_e;

  typedef enum logic [3:0] {
    F_IDLE,
    F_PRENORM,
    F_ALIGN,
    F_ADD,
    F_MUL,
    F_DIV,
    F_NORM,
    F_ROUND,
    F_DONE
  } fpu_state_e;

  typedef struct packed {
    logic   start;
    fp_op_e op;
  } fpu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] result;
  } fpu_rsp_t;

endpackage
`default_nettype wire

// ===== hdl/sbe_fpu.sv =====
// Iterative double-precision add, subtract, multiply and divide unit.
`default_nettype none
module sbe_fpu (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sbe_pkg::fpu_req_t req_i,
  input  logic [63:0]      a_i,
  input  logic [63:0]      b_i,
  output sbe_pkg::fpu_rsp_t rsp_o
);
  import sbe_pkg::*;

  localparam logic signed [13:0] EXP_ONE  = 14'sd1;
  localparam logic signed [13:0] EXP_MAX  = 14'sd2047;
  localparam logic signed [13:0] MUL_BIAS = 14'sd1022;
  localparam logic signed [13:0] DIV_BIAS = 14'sd1023;
  localparam logic [5:0]         MUL_STEPS = 6'd53;
  localparam logic [5:0]         DIV_STEPS = 6'd56;

  fpu_state_e fst_q, fst_d;
  fp_op_e     op_q;
  logic       sa_q, sb_q, sx_q, sr_q;
  logic signed [13:0] ea_q, eb_q, er_q;
  logic [56:0] ma_q, mb_q, r_q;
  logic [53:0] acc_q, rem_q;
  logic [52:0] lo_q;
  logic [5:0]  cnt_q;
  logic [63:0] res_q;

  // Operand classification.
  logic [10:0] ea_f, eb_f;
  logic [51:0] fa, fb;
  logic nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;
  logic sb_eff, sx;
  logic special_hit;
  logic [63:0] special_val;

  assign ea_f   = a_i[62:52];
  assign eb_f   = b_i[62:52];
  assign fa     = a_i[51:0];
  assign fb     = b_i[51:0];
  assign nan_a  = (ea_f == 11'h7FF) && (fa != '0);
  assign nan_b  = (eb_f == 11'h7FF) && (fb != '0);
  assign inf_a  = (ea_f == 11'h7FF) && (fa == '0);
  assign inf_b  = (eb_f == 11'h7FF) && (fb == '0);
  assign zero_a = (a_i[62:0] == '0);
  assign zero_b = (b_i[62:0] == '0);
  assign sb_eff = b_i[63] ^ (req_i.op == FP_SUB);
  assign sx     = a_i[63] ^ b_i[63];

  always_comb begin
    special_hit = 1'b1;
    special_val = CANON_NAN;
    if (nan_a || nan_b) begin
      special_val = CANON_NAN;
    end else begin
      case (req_i.op)
        FP_ADD, FP_SUB: begin
          if (inf_a && inf_b) begin
            special_val = (a_i[63] != sb_eff) ? CANON_NAN : {a_i[63], 11'h7FF, 52'd0};
          end else if (inf_a) begin
            special_val = {a_i[63], 11'h7FF, 52'd0};
          end else if (inf_b) begin
            special_val = {sb_eff, 11'h7FF, 52'd0};
          end else if (zero_a && zero_b) begin
            special_val = {a_i[63] & sb_eff, 63'd0};
          end else if (zero_a) begin
            special_val = {sb_eff, b_i[62:0]};
          end else if (zero_b) begin
            special_val = a_i;
          end else begin
            special_hit = 1'b0;
          end
        end
        FP_MUL: begin
          if ((inf_a && zero_b) || (zero_a && inf_b)) begin
            special_val = CANON_NAN;
          end else if (inf_a || inf_b) begin
            special_val = {sx, 11'h7FF, 52'd0};
          end else if (zero_a || zero_b) begin
            special_val = {sx, 63'd0};
          end else begin
            special_hit = 1'b0;
          end
        end
        default: begin
          if (zero_b) begin
            special_val = zero_a ? CANON_NAN : {sx, 11'h7FF, 52'd0};
          end else if (inf_a) begin
            special_val = inf_b ? CANON_NAN : {sx, 11'h7FF, 52'd0};
          end else if (inf_b || zero_a) begin
            special_val = {sx, 63'd0};
          end else begin
            special_hit = 1'b0;
          end
        end
      endcase
    end
  end

  // Per-step datapath values.
  logic [53:0]  mul_sum;
  logic [105:0] prod;
  logic [53:0]  div_d, div_rem;
  logic         div_ge;
  logic         prenorm_ok, norm_done;
  logic         rnd_up;
  logic [53:0]  rnd_m;
  logic [52:0]  rnd_mant;
  logic signed [13:0] rnd_e;

  assign mul_sum = acc_q + (mb_q[3] ? {1'b0, ma_q[55:3]} : 54'd0);
  assign prod    = {acc_q[52:0], lo_q};
  assign div_d   = {1'b0, mb_q[55:3]};
  assign div_ge  = (rem_q >= div_d);
  assign div_rem = div_ge ? (rem_q - div_d) : rem_q;
  assign prenorm_ok = ma_q[55] && mb_q[55];
  assign norm_done  = !r_q[56] && (r_q[55] || (er_q <= EXP_ONE) || (r_q == '0))
                      && (er_q >= EXP_ONE);

  assign rnd_up   = r_q[2] & (r_q[3] | r_q[1] | r_q[0]);
  assign rnd_m    = {1'b0, r_q[55:3]} + {53'd0, rnd_up};
  assign rnd_mant = rnd_m[53] ? rnd_m[53:1] : rnd_m[52:0];
  assign rnd_e    = rnd_m[53] ? (er_q + EXP_ONE) : er_q;

  always_comb begin
    fst_d = fst_q;
    case (fst_q)
      F_IDLE:    if (req_i.start) fst_d = special_hit ? F_DONE : F_PRENORM;
      F_PRENORM: begin
        if (prenorm_ok) begin
          case (op_q)
            FP_ADD, FP_SUB: fst_d = F_ALIGN;
            FP_MUL:         fst_d = F_MUL;
            default:        fst_d = F_DIV;
          endcase
        end
      end
      F_ALIGN:   if (ea_q == eb_q) fst_d = F_ADD;
      F_ADD:     fst_d = F_NORM;
      F_MUL:     if (cnt_q == MUL_STEPS) fst_d = F_NORM;
      F_DIV:     if (cnt_q == DIV_STEPS) fst_d = F_NORM;
      F_NORM:    if (norm_done) fst_d = F_ROUND;
      F_ROUND:   fst_d = F_DONE;
      F_DONE:    fst_d = F_IDLE;
      default:   fst_d = F_IDLE;
    endcase
  end

  always_comb begin
    rsp_o.done   = (fst_q == F_DONE);
    rsp_o.result = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fst_q <= F_IDLE;
    end else begin
      fst_q <= fst_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (fst_q)
      F_IDLE: begin
        if (req_i.start) begin
          op_q  <= req_i.op;
          sa_q  <= a_i[63];
          sb_q  <= sb_eff;
          sx_q  <= sx;
          res_q <= special_val;
          ma_q  <= {1'b0, ea_f != 11'd0, fa, 3'b000};
          mb_q  <= {1'b0, eb_f != 11'd0, fb, 3'b000};
          ea_q  <= (ea_f == 11'd0) ? EXP_ONE : $signed({3'b000, ea_f});
          eb_q  <= (eb_f == 11'd0) ? EXP_ONE : $signed({3'b000, eb_f});
        end
      end
      F_PRENORM: begin
        if (!ma_q[55]) begin
          ma_q <= {ma_q[55:0], 1'b0};
          ea_q <= ea_q - EXP_ONE;
        end else if (!mb_q[55]) begin
          mb_q <= {mb_q[55:0], 1'b0};
          eb_q <= eb_q - EXP_ONE;
        end else begin
          acc_q <= '0;
          lo_q  <= '0;
          cnt_q <= '0;
          r_q   <= '0;
          rem_q <= {1'b0, ma_q[55:3]};
        end
      end
      F_ALIGN: begin
        // Shift the smaller operand right one place a cycle, folding lost bits
        // into the sticky bit.
        if (ea_q > eb_q) begin
          if (mb_q[56:1] == '0) eb_q <= ea_q;
          else begin
            mb_q <= {1'b0, mb_q[56:2], mb_q[1] | mb_q[0]};
            eb_q <= eb_q + EXP_ONE;
          end
        end else if (eb_q > ea_q) begin
          if (ma_q[56:1] == '0) ea_q <= eb_q;
          else begin
            ma_q <= {1'b0, ma_q[56:2], ma_q[1] | ma_q[0]};
            ea_q <= ea_q + EXP_ONE;
          end
        end
      end
      F_ADD: begin
        er_q <= ea_q;
        if (sa_q == sb_q) begin
          r_q  <= ma_q + mb_q;
          sr_q <= sa_q;
        end else if (ma_q >= mb_q) begin
          r_q  <= ma_q - mb_q;
          sr_q <= (ma_q == mb_q) ? 1'b0 : sa_q;
        end else begin
          r_q  <= mb_q - ma_q;
          sr_q <= sb_q;
        end
      end
      F_MUL: begin
        if (cnt_q != MUL_STEPS) begin
          acc_q <= {1'b0, mul_sum[53:1]};
          lo_q  <= {mul_sum[0], lo_q[52:1]};
          mb_q  <= {1'b0, mb_q[56:1]};
          cnt_q <= cnt_q + 6'd1;
        end else begin
          r_q  <= {1'b0, prod[105:51], prod[50] | (|prod[49:0])};
          er_q <= ea_q + eb_q - MUL_BIAS;
          sr_q <= sx_q;
        end
      end
      F_DIV: begin
        if (cnt_q != DIV_STEPS) begin
          rem_q <= {div_rem[52:0], 1'b0};
          r_q   <= {r_q[55:0], div_ge};
          cnt_q <= cnt_q + 6'd1;
        end else begin
          r_q[0] <= r_q[0] | (rem_q != '0);
          er_q   <= ea_q - eb_q + DIV_BIAS;
          sr_q   <= sx_q;
        end
      end
      F_NORM: begin
        if (r_q[56]) begin
          r_q  <= {1'b0, r_q[56:2], r_q[1] | r_q[0]};
          er_q <= er_q + EXP_ONE;
        end else if (!r_q[55] && (er_q > EXP_ONE) && (r_q != '0)) begin
          r_q  <= {r_q[55:0], 1'b0};
          er_q <= er_q - EXP_ONE;
        end else if (er_q < EXP_ONE) begin
          if (r_q[56:1] == '0) er_q <= EXP_ONE;
          else begin
            r_q  <= {1'b0, r_q[56:2], r_q[1] | r_q[0]};
            er_q <= er_q + EXP_ONE;
          end
        end
      end
      F_ROUND: begin
        if (rnd_e >= EXP_MAX) res_q <= {sr_q, 11'h7FF, 52'd0};
        else res_q <= {sr_q, rnd_mant[52] ? rnd_e[10:0] : 11'd0, rnd_mant[51:0]};
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/stack_bytecode_executor.sv =====
// Top level of the stack bytecode executor: sequencer, value stack and result register.
`default_nettype none
//
//  Channel  Direction  tdata                                 tuser
//  s_axis   in         [63:0] constant_bits                  [2:0] op, [3] constant_is_number
//  m_axis   out        [63:0] value_bits, [72:64] depth      [2:0] status, [3] value_is_number
//
// One instruction is taken at a time. Add and subtract run through the
// one-place-per-cycle alignment and normalization shifts of the shared FPU; multiply
// and divide run through its one-bit-per-cycle multiplier and divider loop. Each
// subnormal operand adds pre-normalization shifts, and a subnormal result adds right
// shifts. A finished result waits in the output register while the next instruction
// is taken; the sequencer stalls in its last state only when a second result is ready
// before the first has been taken. Reset empties the stack.
module stack_bytecode_executor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // constant_bits
  input  logic [3:0]  s_axis_tuser,   // op, constant_is_number
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata,   // value_bits, depth, zero fill
  output logic [3:0]  m_axis_tuser    // status, value_is_number
);
  import sbe_pkg::*;

  top_state_e state_q, state_d;
  op_e        op_q;
  logic [ENTRY_W-1:0] const_q;
  logic [ENTRY_W-1:0] top_q;      // top of stack lives in a register
  logic [ENTRY_W-1:0] rd_q;       // registered stack memory read data
  logic [ENTRY_W-1:0] ret_q;
  logic               ret_flag_q;
  logic [SP_W-1:0]    sp_q;
  status_e            st_q;

  logic [ENTRY_W-1:0] stack_mem [STACK_DEPTH];

  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic               fpu_go;
  fpu_req_t           fpu_req;
  fpu_rsp_t           fpu_rsp;

  logic is_push, is_ret, is_neg, sp_full, sp_lt1, sp_lt2, out_free;
  logic [SP_W-1:0] sp_m1, sp_m2;

  assign is_push  = (op_q == OP_CONST) || (op_q == OP_CONST_LONG);
  assign is_ret   = (op_q == OP_RET);
  assign is_neg   = (op_q == OP_NEG);
  assign sp_full  = (sp_q == SP_W'(STACK_DEPTH));
  assign sp_lt1   = (sp_q == '0);
  assign sp_lt2   = (sp_q < SP_W'(2));
  assign sp_m1    = sp_q - SP_W'(1);
  assign sp_m2    = sp_q - SP_W'(2);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    case (op_q)
      OP_ADD:  fpu_req.op = FP_ADD;
      OP_SUB:  fpu_req.op = FP_SUB;
      OP_MUL:  fpu_req.op = FP_MUL;
      default: fpu_req.op = FP_DIV;
    endcase
    fpu_req.start = fpu_go;
  end

  sbe_fpu u_fpu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (fpu_req),
    .a_i    (rd_q[63:0]),
    .b_i    (top_q[63:0]),
    .rsp_o  (fpu_rsp)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      T_IDLE: if (s_axis_tvalid) state_d = T_EXEC;
      T_EXEC: begin
        if (is_push || is_neg) state_d = T_FINISH;
        else if (is_ret) state_d = sp_lt2 ? T_FINISH : T_READ;
        else if (sp_lt2 || !top_q[64]) state_d = T_FINISH;
        else state_d = T_READ;
      end
      T_READ: begin
        if (is_ret || !rd_q[64]) state_d = T_FINISH;
        else state_d = T_ARITH;
      end
      T_ARITH:  if (fpu_rsp.done) state_d = T_FINISH;
      T_FINISH: if (out_free) state_d = T_IDLE;
      default:  state_d = T_IDLE;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    s_axis_tready = (state_q == T_IDLE);
    mem_we        = (state_q == T_EXEC) && is_push && !sp_full && !sp_lt1;
    mem_waddr     = sp_m1[ADDR_W-1:0];
    mem_raddr     = sp_m2[ADDR_W-1:0];
    fpu_go        = (state_q == T_READ) && !is_ret && rd_q[64];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) stack_mem[mem_waddr] <= top_q;
  end

  always_ff @(posedge clk_i) begin
    rd_q <= stack_mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= T_IDLE;
      sp_q          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state_q <= state_d;
      if ((state_q == T_FINISH) && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
      case (state_q)
        T_EXEC: begin
          if (is_push) begin
            if (!sp_full) sp_q <= sp_q + SP_W'(1);
          end else if (is_neg) begin
            if (!sp_lt1 && !top_q[64]) sp_q <= '0;
          end else if (is_ret) begin
            if (!sp_lt1) sp_q <= sp_m1;
          end else if (!sp_lt2 && !top_q[64]) begin
            sp_q <= '0;
          end
        end
        T_READ: if (!is_ret && !rd_q[64]) sp_q <= '0;
        T_ARITH: if (fpu_rsp.done) sp_q <= sp_m1;
        default: ;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      T_IDLE: begin
        if (s_axis_tvalid) begin
          op_q       <= op_e'(s_axis_tuser[2:0]);
          const_q    <= {s_axis_tuser[3], s_axis_tdata};
          ret_flag_q <= 1'b0;
          st_q       <= ST_OK;
        end
      end
      T_EXEC: begin
        if (is_push) begin
          if (sp_full) st_q <= ST_OVER;
          else top_q <= const_q;
        end else if (is_neg) begin
          if (sp_lt1) st_q <= ST_UNDER;
          else if (!top_q[64]) st_q <= ST_TYPE;
          else top_q[63] <= ~top_q[63];
        end else if (is_ret) begin
          if (sp_lt1) st_q <= ST_UNDER;
          else begin
            st_q       <= ST_RET;
            ret_q      <= top_q;
            ret_flag_q <= 1'b1;
          end
        end else if (sp_lt2) begin
          st_q <= ST_UNDER;
        end else if (!top_q[64]) begin
          st_q <= ST_TYPE;
        end
      end
      T_READ: begin
        if (is_ret) top_q <= rd_q;
        else if (!rd_q[64]) st_q <= ST_TYPE;
      end
      T_ARITH: if (fpu_rsp.done) top_q <= {1'b1, fpu_rsp.result};
      T_FINISH: begin
        if (out_free) begin
          m_axis_tuser[2:0]    <= st_q;
          m_axis_tdata[72:64]  <= DEPTH_W'(sp_q);
          m_axis_tdata[79:73]  <= '0;
          if (ret_flag_q) begin
            m_axis_tdata[63:0] <= ret_q[63:0];
            m_axis_tuser[3]    <= ret_q[64];
          end else if (sp_lt1) begin
            m_axis_tdata[63:0] <= '0;
            m_axis_tuser[3]    <= 1'b0;
          end else begin
            m_axis_tdata[63:0] <= top_q[63:0];
            m_axis_tuser[3]    <= top_q[64];
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire
